@@ sv/sle_pkg.sv @@
`default_nettype none

package sle_pkg;

    // Widths of the word fields, fixed by the interface definition.
    localparam int FW = 7;
    localparam int VW = 32;

    // Request codes.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_LOCATE = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // Status of one finished request, handed from the sequencer to the output stage.
    typedef struct packed {
        logic                 ok;
        logic signed [VW-1:0] value;
        logic [FW-1:0]        fpos;
        logic [FW-1:0]        removed;
        logic [FW-1:0]        length;
        logic                 empty;
    } t_result;

endpackage

`default_nettype wire

@@ sv/sle_if.sv @@
`default_nettype none

interface sle_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [6:0]         position;
    logic signed [31:0] item_value;

    modport source (output valid, req_type, position, item_value, input ready);
    modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

interface sle_rsp_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] value_out;
    logic [6:0]         found_position;
    logic [6:0]         removed_count;
    logic [6:0]         list_length;
    logic               is_empty;

    modport source (output valid, ok, value_out, found_position, removed_count,
                    list_length, is_empty, input ready);
    modport sink   (input valid, ok, value_out, found_position, removed_count,
                    list_length, is_empty, output ready);
endinterface

`default_nettype wire

@@ sv/sle_ram.sv @@
`default_nettype none

module sle_ram import sle_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output logic signed [VW-1:0]      o_rdata,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic signed [VW-1:0] i_wdata
);

    logic signed [VW-1:0] r_mem [DEPTH];
    logic signed [VW-1:0] r_rdata;

    // One write port and one read port; read data is registered and appears in the cycle after the read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/sle_seq.sv @@
`default_nettype none

module sle_seq import sle_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire logic [2:0]           i_req_type,
    input  wire logic [FW-1:0]        i_position,
    input  wire logic signed [VW-1:0] i_item_value,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output t_result                   o_res,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    input  wire logic signed [VW-1:0] i_rdata,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic signed [VW-1:0]      o_wdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > FW) ? CW : FW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [2:0]           r_op;
    logic signed [VW-1:0] r_val;
    logic [CW-1:0]        r_idx, r_count, r_rd, r_left, r_da, r_k, r_fpos, r_removed;
    logic                 r_dv, r_ok, r_found;
    logic signed [VW-1:0] r_vout;

    logic                 n_ok;
    logic [CW-1:0]        n_left, n_rd;

    logic [PW-1:0] pos_w, cnt_w;
    logic [CW-1:0] idx_c, da_inc, da_dec;
    logic          accept, ins_ok, at_ok, go_scan, issue, scan_end, match;

    assign pos_w    = PW'(i_position);
    assign cnt_w    = PW'(r_count);
    assign idx_c    = CW'(pos_w - PW'(1));
    assign ins_ok   = (pos_w != '0) && (pos_w <= cnt_w + PW'(1)) && (r_count != CW'(DEPTH));
    assign at_ok    = (pos_w != '0) && (pos_w <= cnt_w);
    assign accept   = (r_state == S_IDLE) && i_req_valid;
    assign da_inc   = r_da + CW'(1);
    assign da_dec   = r_da - CW'(1);
    assign issue    = (r_state == S_SCAN) && (r_left != '0) && !r_found;
    assign scan_end = (r_state == S_SCAN) && ((r_left == '0) || r_found) && !r_dv;
    assign match    = r_dv && (i_rdata == r_val);

    always_comb begin
        case (i_req_type)
            OP_INSERT: go_scan = ins_ok;
            OP_DELETE: go_scan = at_ok;
            OP_GET:    go_scan = at_ok;
            OP_LOCATE: go_scan = 1'b1;
            OP_REMOVE: go_scan = 1'b1;
            default:   go_scan = 1'b0;
        endcase
    end

    // Status, walk length and first read address of a request being accepted.
    always_comb begin
        n_ok   = 1'b0;
        n_left = '0;
        n_rd   = '0;
        case (i_req_type)
            OP_INSERT: begin
                n_ok = ins_ok;
                if (ins_ok) begin
                    n_left = r_count - idx_c;
                    n_rd   = r_count - CW'(1);
                end
            end
            OP_DELETE: begin
                n_ok = at_ok;
                if (at_ok) begin
                    n_left = r_count - idx_c;
                    n_rd   = idx_c;
                end
            end
            OP_GET: begin
                n_ok = at_ok;
                if (at_ok) begin
                    n_left = CW'(1);
                    n_rd   = idx_c;
                end
            end
            OP_LOCATE: begin
                n_left = r_count;
            end
            OP_REMOVE: begin
                n_ok   = 1'b1;
                n_left = r_count;
            end
            OP_CLEAR: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? (go_scan ? S_SCAN : S_DONE) : S_IDLE;
            S_SCAN:  n_state = scan_end ? S_DONE : S_SCAN;
            S_DONE:  n_state = i_res_ready ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Store port: one read issued ahead, one write of the word that returned.
    assign o_re    = issue;
    assign o_raddr = r_rd[AW-1:0];
    assign o_wdata = r_dv ? i_rdata : r_val;

    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_idx[AW-1:0];
        if (r_dv) begin
            case (r_op)
                OP_INSERT: begin
                    o_we    = 1'b1;
                    o_waddr = da_inc[AW-1:0];
                end
                OP_DELETE: begin
                    o_we    = (r_da != r_idx);
                    o_waddr = da_dec[AW-1:0];
                end
                OP_REMOVE: begin
                    o_we    = !match;
                    o_waddr = r_k[AW-1:0];
                end
                default: begin
                    o_we = 1'b0;
                end
            endcase
        end else if (scan_end && (r_op == OP_INSERT)) begin
            o_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= issue;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_req_type;
                        r_val     <= i_item_value;
                        r_idx     <= idx_c;
                        r_ok      <= n_ok;
                        r_vout    <= '0;
                        r_found   <= 1'b0;
                        r_fpos    <= '0;
                        r_removed <= '0;
                        r_k       <= '0;
                        r_left    <= n_left;
                        r_rd      <= n_rd;
                        if (i_req_type == OP_CLEAR) begin
                            r_count <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_da   <= r_rd;
                        r_rd   <= (r_op == OP_INSERT) ? r_rd - CW'(1) : r_rd + CW'(1);
                        r_left <= r_left - CW'(1);
                    end
                    if (r_dv) begin
                        case (r_op)
                            OP_DELETE: begin
                                if (r_da == r_idx) begin
                                    r_vout <= i_rdata;
                                end
                            end
                            OP_GET: begin
                                r_vout <= i_rdata;
                            end
                            OP_LOCATE: begin
                                if (match && !r_found) begin
                                    r_found <= 1'b1;
                                    r_ok    <= 1'b1;
                                    r_fpos  <= da_inc;
                                end
                            end
                            OP_REMOVE: begin
                                if (!match) begin
                                    r_k <= r_k + CW'(1);
                                end
                            end
                            default: begin
                                r_k <= r_k;
                            end
                        endcase
                    end
                    if (scan_end) begin
                        case (r_op)
                            OP_INSERT: r_count <= r_count + CW'(1);
                            OP_DELETE: r_count <= r_count - CW'(1);
                            OP_REMOVE: begin
                                r_count   <= r_k;
                                r_removed <= r_count - r_k;
                            end
                            default:   r_count <= r_count;
                        endcase
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_res_valid   = (r_state == S_DONE);
    assign o_res.ok      = r_ok;
    assign o_res.value   = r_vout;
    assign o_res.fpos    = FW'(r_fpos);
    assign o_res.removed = FW'(r_removed);
    assign o_res.length  = FW'(r_count);
    assign o_res.empty   = (r_count == '0);

endmodule

`default_nettype wire

@@ sv/sequential_list_engine_unit.sv @@
// Channel   Direction  Modport  Word carried
// i_req     in         sink     req_type, position, item_value
// o_rsp     out        source   ok, value_out, found_position, removed_count,
//                               list_length, is_empty
//
// Requests are handled one at a time. Clear, a rejected request and an unused
// code go straight to a result; get reads one entry; insert, delete, locate
// and remove-all walk the entries one at a time, limited by the single read
// port and single write port of the store.
// Reset is synchronous and active low; it empties the list but leaves the store
// contents as they are. The result waits in an output register, so a new
// request is taken while the previous word is still held by a stalled sink.
`default_nettype none

module sequential_list_engine_unit import sle_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sle_req_if.sink   i_req,
    sle_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);

    // Sequencer to output stage.
    t_result res;
    logic    res_valid;
    logic    res_ready;

    // Store port.
    logic                 mem_re;
    logic                 mem_we;
    logic [AW-1:0]        mem_raddr;
    logic [AW-1:0]        mem_waddr;
    logic signed [VW-1:0] mem_rdata;
    logic signed [VW-1:0] mem_wdata;

    // Output register state.
    logic    r_rsp_valid;
    t_result r_rsp;

    // The sequencer walks the store: it issues one read a cycle and writes
    // back the word that returned the cycle before, so reads always run ahead
    // of the writes that move entries and never meet them at one address.
    sle_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .o_req_ready  (i_req.ready),
        .i_req_type   (i_req.req_type),
        .i_position   (i_req.position),
        .i_item_value (i_req.item_value),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_re         (mem_re),
        .o_raddr      (mem_raddr),
        .i_rdata      (mem_rdata),
        .o_we         (mem_we),
        .o_waddr      (mem_waddr),
        .o_wdata      (mem_wdata)
    );

    // Entry store, one word per list position.
    sle_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

    // The output register takes a new result when it is empty or when its
    // current word leaves in the same cycle.
    assign res_ready = !r_rsp_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (res_ready) begin
            r_rsp_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_rsp <= res;
        end
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.ok             = r_rsp.ok;
    assign o_rsp.value_out      = r_rsp.value;
    assign o_rsp.found_position = r_rsp.fpos;
    assign o_rsp.removed_count  = r_rsp.removed;
    assign o_rsp.list_length    = r_rsp.length;
    assign o_rsp.is_empty       = r_rsp.empty;

endmodule

`default_nettype wire

@@ sv/sle_chk.sv @@
`default_nettype none

module sle_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic        i_rsp_ok,
    input wire logic [31:0] i_rsp_value,
    input wire logic [6:0]  i_rsp_fpos,
    input wire logic [6:0]  i_rsp_len,
    input wire logic        i_rsp_empty
);

    // No result word may come out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result word valid straight after reset");

    // A held result keeps its contents until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_len)
            && $stable(i_rsp_ok))
        else $error("stalled result word changed");

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in progress");

    // Emptiness agrees with the length, and a found position implies success.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_empty == (i_rsp_len == 7'd0))
            && ((i_rsp_fpos == 7'd0) || i_rsp_ok))
        else $error("inconsistent result status");

endmodule

bind sequential_list_engine_unit sle_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_ok    (o_rsp.ok),
    .i_rsp_value (o_rsp.value_out),
    .i_rsp_fpos  (o_rsp.found_position),
    .i_rsp_len   (o_rsp.list_length),
    .i_rsp_empty (o_rsp.is_empty)
);

`default_nettype wire

@@ tb/sv/sequential_list_engine_unit_tb.sv @@
module sequential_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    // The block under test keeps at most this many entries.
    localparam int DEPTH = 64;

    // The two request codes that the package leaves unused. The block must answer
    // them with a word that changes nothing.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    localparam int RANDOM_WORDS = 525;
    localparam int BLOCK_WORDS  = 50;

    // The random part runs in blocks of words. Each block leans towards growing,
    // shrinking or churning the list, so that the list is driven to full and
    // back to empty several times over the run.
    typedef enum int {PH_GROW, PH_MIX, PH_SHRINK} t_phase;

    localparam t_phase PHASE_PLAN [6] = '{PH_GROW, PH_GROW, PH_MIX,
                                          PH_SHRINK, PH_SHRINK, PH_MIX};

    // Cumulative weights, in per cent, for insert, delete, get, locate, remove,
    // clear and the unused codes, one row per phase.
    localparam int OP_WEIGHT [3][7] = '{'{80, 85, 90, 95, 98, 98, 100},
                                        '{35, 55, 70, 83, 92, 95, 100},
                                        '{10, 60, 70, 80, 95, 95, 100}};

    localparam logic [2:0] OP_ORDER [7] = '{OP_INSERT, OP_DELETE, OP_GET, OP_LOCATE,
                                           OP_REMOVE, OP_CLEAR, OP_SPARE_6};

    // Values that are likely to collide, so that locate and remove find matches
    // and duplicates build up in the list.
    localparam logic signed [31:0] VALUE_POOL [8] = '{32'sd0, -32'sd1, VAL_MIN, VAL_MAX,
                                                     32'sd1, 32'sd2, 32'sh5555_5555,
                                                     32'shAAAA_AAAA};

    // One row of the directed table. Where typed is set, the word in want is the
    // answer that the block must give; otherwise the list model decides.
    typedef struct {
        logic [2:0]         op;
        logic [6:0]         pos;
        logic signed [31:0] val;
        bit                 typed;
        t_result            want;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sle_req_if req_ch ();
    sle_rsp_if rsp_ch ();

    sequential_list_engine_unit #(
        .DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Model of the list contents, in list order, and the words still owed by the
    // block, oldest first.
    logic signed [31:0] list_model [$];
    t_result            owed_words [$];

    bit calm     = 1'b0;
    bit hold_off = 1'b0;

    int accepted_count = 0;
    int checked_count  = 0;
    int error_count    = 0;
    int peak_length    = 0;
    int full_rejects   = 0;
    int op_count [8]   = '{default: 0};

    t_dir_row directed_rows [25];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run must finish well inside this time, even with every request walking
    // the whole list and every word meeting a stalled sink.
    initial begin
        #5_000_000;
        $display("timeout: %0d words still owed", owed_words.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_result mk_result(input bit ok, input logic signed [31:0] value,
                                          input int fpos, input int removed,
                                          input int length, input bit empty);
        t_result r;
        r.ok      = ok;
        r.value   = value;
        r.fpos    = 7'(fpos);
        r.removed = 7'(removed);
        r.length  = 7'(length);
        r.empty   = empty;
        return r;
    endfunction

    // Applies one accepted request to the list model and returns the word that
    // the block should answer with.
    function automatic t_result apply_request(input logic [2:0] op, input logic [6:0] pos,
                                              input logic signed [31:0] val);
        t_result            r;
        int                 n;
        logic signed [31:0] kept [$];
        r = '0;
        n = list_model.size();
        case (op)
            OP_INSERT: begin
                // A full list turns away every insert, even at a sound position.
                if (n == DEPTH) full_rejects++;
                if (pos >= 1 && pos <= n + 1 && n < DEPTH) begin
                    list_model.insert(pos - 1, val);
                    r.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos >= 1 && pos <= n) begin
                    r.value = list_model[pos - 1];
                    list_model.delete(pos - 1);
                    r.ok = 1'b1;
                end
            end
            OP_GET: begin
                if (pos >= 1 && pos <= n) begin
                    r.value = list_model[pos - 1];
                    r.ok = 1'b1;
                end
            end
            OP_LOCATE: begin
                // Only the first match counts; no match leaves ok and the position
                // at zero.
                for (int i = 0; i < n; i++) begin
                    if (list_model[i] == val) begin
                        r.ok   = 1'b1;
                        r.fpos = 7'(i + 1);
                        break;
                    end
                end
            end
            OP_REMOVE: begin
                // Survivors keep their order. This succeeds even when nothing
                // matched.
                foreach (list_model[i]) begin
                    if (list_model[i] != val) kept.push_back(list_model[i]);
                end
                r.removed  = 7'(n - kept.size());
                list_model = kept;
                r.ok       = 1'b1;
            end
            OP_CLEAR: begin
                list_model.delete();
                r.ok = 1'b1;
            end
            default: begin
                // The unused codes change nothing and report only the length and emptiness.
            end
        endcase
        r.length = 7'(list_model.size());
        r.empty  = (list_model.size() == 0);
        if (list_model.size() > peak_length) peak_length = list_model.size();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s is %h, expected %h", checked_count, what, got, want);
        error_count++;
    endtask

    // Offers one request word and waits for the block to take it. Before the word
    // goes out, the sender may idle at random with valid low, except in the calm
    // stretch; once valid is up it stays up until the handshake.
    task automatic offer_word(input logic [2:0] op, input logic [6:0] pos,
                              input logic signed [31:0] val, input bit typed,
                              input t_result want);
        t_result predicted;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 26) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.req_type   = op;
        req_ch.position   = pos;
        req_ch.item_value = val;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = apply_request(op, pos, val);
        owed_words.push_back(typed ? want : predicted);
        op_count[op]++;
        accepted_count++;
    endtask

    // The sink takes words at random, except during the calm stretch, when it is
    // always ready, and during the hold-off, when it takes nothing at all.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = !hold_off && (calm || $urandom_range(0, 99) >= 26);
        end
    end

    // Once the list is busy, the sink holds off for a long stretch while the
    // sender keeps offering words. With one word parked at the output and the
    // next one finished behind it, the block has to stop taking requests.
    initial begin
        wait (accepted_count >= 120);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Every result word that the sink takes is matched against the oldest word
    // still owed.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (owed_words.size() == 0) begin
                report_mismatch("word with nothing owed, list_length",
                                32'(rsp_ch.list_length), 32'd0);
            end else begin
                want = owed_words.pop_front();
                if (rsp_ch.ok !== want.ok)
                    report_mismatch("ok", 32'(rsp_ch.ok), 32'(want.ok));
                if (rsp_ch.value_out !== want.value)
                    report_mismatch("value_out", rsp_ch.value_out, want.value);
                if (rsp_ch.found_position !== want.fpos)
                    report_mismatch("found_position", 32'(rsp_ch.found_position),
                                    32'(want.fpos));
                if (rsp_ch.removed_count !== want.removed)
                    report_mismatch("removed_count", 32'(rsp_ch.removed_count),
                                    32'(want.removed));
                if (rsp_ch.list_length !== want.length)
                    report_mismatch("list_length", 32'(rsp_ch.list_length),
                                    32'(want.length));
                if (rsp_ch.is_empty !== want.empty)
                    report_mismatch("is_empty", 32'(rsp_ch.is_empty), 32'(want.empty));
                checked_count++;
            end
        end
    end

    initial begin
        logic [2:0]         op;
        logic [6:0]         pos;
        logic signed [31:0] val;
        t_phase             ph;
        int                 roll;
        int                 k;
        int                 n;

        req_ch.valid      = 1'b0;
        req_ch.req_type   = OP_CLEAR;
        req_ch.position   = '0;
        req_ch.item_value = '0;

        // Directed part. It starts on the empty list, builds a short list holding
        // both extremes of the value range, and works every request code against
        // it, including positions out of range and the unused codes, before
        // clearing the list and trying the requests that an empty list allows.
        directed_rows = '{
            '{OP_GET,     7'd1,   32'sd0,     1'b1, mk_result(0, 0, 0, 0, 0, 1)},
            '{OP_DELETE,  7'd0,   32'sd0,     1'b1, mk_result(0, 0, 0, 0, 0, 1)},
            '{OP_INSERT,  7'd0,   32'sd5,     1'b1, mk_result(0, 0, 0, 0, 0, 1)},
            '{OP_INSERT,  7'd2,   32'sd5,     1'b1, mk_result(0, 0, 0, 0, 0, 1)},
            '{OP_INSERT,  7'd1,   VAL_MAX,    1'b1, mk_result(1, 0, 0, 0, 1, 0)},
            '{OP_INSERT,  7'd1,   VAL_MIN,    1'b1, mk_result(1, 0, 0, 0, 2, 0)},
            '{OP_INSERT,  7'd3,   32'sd0,     1'b1, mk_result(1, 0, 0, 0, 3, 0)},
            '{OP_INSERT,  7'd2,   -32'sd1,    1'b0, '0},
            '{OP_GET,     7'd4,   32'sd0,     1'b0, '0},
            '{OP_GET,     7'd1,   32'sd0,     1'b1, mk_result(1, VAL_MIN, 0, 0, 4, 0)},
            '{OP_GET,     7'd5,   32'sd0,     1'b0, '0},
            '{OP_LOCATE,  7'd0,   VAL_MAX,    1'b0, '0},
            '{OP_LOCATE,  7'd0,   32'sd12345, 1'b0, '0},
            '{OP_INSERT,  7'd127, 32'sd77,    1'b0, '0},
            '{OP_DELETE,  7'd127, 32'sd0,     1'b0, '0},
            '{OP_DELETE,  7'd1,   32'sd0,     1'b0, '0},
            '{OP_INSERT,  7'd4,   -32'sd1,    1'b0, '0},
            '{OP_REMOVE,  7'd0,   -32'sd1,    1'b0, '0},
            '{OP_REMOVE,  7'd0,   32'sd55,    1'b0, '0},
            '{OP_SPARE_6, 7'd127, -32'sd1,    1'b0, '0},
            '{OP_SPARE_7, 7'd0,   32'sd0,     1'b0, '0},
            '{OP_CLEAR,   7'd0,   32'sd0,     1'b1, mk_result(1, 0, 0, 0, 0, 1)},
            '{OP_CLEAR,   7'd0,   32'sd0,     1'b1, mk_result(1, 0, 0, 0, 0, 1)},
            '{OP_REMOVE,  7'd0,   32'sd0,     1'b1, mk_result(1, 0, 0, 0, 0, 1)},
            '{OP_LOCATE,  7'd0,   32'sd0,     1'b1, mk_result(0, 0, 0, 0, 0, 1)}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            offer_word(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val,
                       directed_rows[r].typed, directed_rows[r].want);
        end

        // Random part. Most positions are sound for the current length, so that
        // inserts and deletes really move entries about; the rest fall outside
        // the list. Locate and remove mostly look for a value that is present.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= 230 && i < 310);
            ph   = PHASE_PLAN[(i / BLOCK_WORDS) % 6];
            roll = $urandom_range(0, 99);
            k    = 0;
            while (roll >= OP_WEIGHT[int'(ph)][k]) k++;
            op = OP_ORDER[k];
            if (op == OP_SPARE_6 && $urandom_range(0, 1) == 1) op = OP_SPARE_7;

            n   = list_model.size();
            pos = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 99) < 85) begin
                if (op == OP_INSERT)
                    pos = 7'($urandom_range(1, n + 1));
                else if ((op == OP_DELETE || op == OP_GET) && n > 0)
                    pos = 7'($urandom_range(1, n));
            end

            if ((op == OP_LOCATE || op == OP_REMOVE) && n > 0 && $urandom_range(0, 99) < 70)
                val = list_model[$urandom_range(0, n - 1)];
            else if ($urandom_range(0, 99) < 40)
                val = VALUE_POOL[$urandom_range(0, 7)];
            else
                val = $urandom;

            offer_word(op, pos, val, 1'b0, '0);
        end
        calm = 1'b0;

        @(negedge i_clk);
        req_ch.valid = 1'b0;

        // Let the last words drain, then allow for a full walk of the list so that
        // any stray word would still be caught.
        while (owed_words.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("%0d request words sent, %0d result words checked, %0d mismatches",
                 accepted_count, checked_count, error_count);
        $display("list peaked at %0d of %0d entries, %0d inserts met a full list; "
                 , peak_length, DEPTH, full_rejects,
                 "by code: ins %0d del %0d get %0d loc %0d rem %0d clr %0d spare %0d",
                 op_count[OP_INSERT], op_count[OP_DELETE], op_count[OP_GET],
                 op_count[OP_LOCATE], op_count[OP_REMOVE], op_count[OP_CLEAR],
                 op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
